>>> rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants for the replay-triggered RX2 switcher.
// ----------------------------------------------------------------------------
package rts_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_DOWNLINK = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  // Register map, index = byte address / 4
  localparam logic [2:0] REG_UL_FREQ  = 3'd0;
  localparam logic [2:0] REG_UL_BW    = 3'd1;
  localparam logic [2:0] REG_UL_SF    = 3'd2;
  localparam logic [2:0] REG_RX2_FREQ = 3'd3;
  localparam logic [2:0] REG_RX2_SF   = 3'd4;
  localparam logic [2:0] REG_WINDOW   = 3'd5;
  localparam logic [2:0] REG_HOLD     = 3'd6;

  localparam int CFG_AW = 5;
  localparam int DEF_MAX_FRAME_BYTES = 256;

  localparam logic [29:0] RST_UL_FREQ  = 30'd868300000;
  localparam logic [8:0]  RST_UL_BW    = 9'd125;
  localparam logic [3:0]  RST_UL_SF    = 4'd12;
  localparam logic [29:0] RST_RX2_FREQ = 30'd869525000;
  localparam logic [3:0]  RST_RX2_SF   = 4'd12;
  localparam logic [15:0] RST_WINDOW   = 16'd3000;
  localparam logic [15:0] RST_HOLD     = 16'd2500;

  localparam logic [8:0]  RX2_BW_KHZ   = 9'd125;
  localparam logic [15:0] AGE_MAX      = 16'hFFFF;

  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic [29:0] ul_freq;
    logic [8:0]  ul_bw;
    logic [3:0]  ul_sf;
    logic [29:0] rx2_freq;
    logic [3:0]  rx2_sf;
    logic [15:0] window;
    logic [15:0] hold;
  } cfg_t;

endpackage

>>> rtl/rts_cfg.sv
// ----------------------------------------------------------------------------
// rts_cfg
// APB register bank for tuning and timing settings.
// ----------------------------------------------------------------------------
module rts_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rts_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rts_pkg::cfg_t              cfg
);
  import rts_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ul_freq  <= RST_UL_FREQ;
      cfg_r.ul_bw    <= RST_UL_BW;
      cfg_r.ul_sf    <= RST_UL_SF;
      cfg_r.rx2_freq <= RST_RX2_FREQ;
      cfg_r.rx2_sf   <= RST_RX2_SF;
      cfg_r.window   <= RST_WINDOW;
      cfg_r.hold     <= RST_HOLD;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_UL_FREQ:  cfg_r.ul_freq  <= pwdata[29:0];
        REG_UL_BW:    cfg_r.ul_bw    <= pwdata[8:0];
        REG_UL_SF:    cfg_r.ul_sf    <= pwdata[3:0];
        REG_RX2_FREQ: cfg_r.rx2_freq <= pwdata[29:0];
        REG_RX2_SF:   cfg_r.rx2_sf   <= pwdata[3:0];
        REG_WINDOW:   cfg_r.window   <= pwdata[15:0];
        REG_HOLD:     cfg_r.hold     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UL_FREQ:  prdata = {2'b0, cfg_r.ul_freq};
      REG_UL_BW:    prdata = {23'b0, cfg_r.ul_bw};
      REG_UL_SF:    prdata = {28'b0, cfg_r.ul_sf};
      REG_RX2_FREQ: prdata = {2'b0, cfg_r.rx2_freq};
      REG_RX2_SF:   prdata = {28'b0, cfg_r.rx2_sf};
      REG_WINDOW:   prdata = {16'b0, cfg_r.window};
      REG_HOLD:     prdata = {16'b0, cfg_r.hold};
      default:      prdata = 32'b0;
    endcase
  end

endmodule

>>> rtl/rts_byte_store.sv
// ----------------------------------------------------------------------------
// rts_byte_store
// Frame byte memory with byte-index counter, registered read and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module rts_byte_store #(
  parameter  int MAX_FRAME_BYTES = rts_pkg::DEF_MAX_FRAME_BYTES,
  localparam int AW = $clog2(MAX_FRAME_BYTES),
  localparam int IW = $clog2(MAX_FRAME_BYTES + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_req,
  input  logic [1:0]    rd_cmd,
  input  logic          rd_last,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data,
  output logic [IW-1:0] rd_idx
);
  import rts_pkg::*;

  localparam logic [IW-1:0] IDX_MAX  = IW'(MAX_FRAME_BYTES);
  localparam logic [IW-1:0] IDX_OVER = IW'(MAX_FRAME_BYTES + 1);

  logic [7:0]    mem [MAX_FRAME_BYTES];
  logic [7:0]    mem_q_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic [IW-1:0] byte_index_r, byte_index_nxt;
  logic [IW-1:0] rd_idx_r;
  logic [AW-1:0] raddr;

  assign raddr   = byte_index_r[AW-1:0];
  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;
  assign rd_idx  = rd_idx_r;

  always_comb begin
    byte_index_nxt = byte_index_r;
    if (rd_req && rd_cmd == CMD_BYTE) begin
      if (rd_last)
        byte_index_nxt = '0;
      else if (byte_index_r < IDX_MAX)
        byte_index_nxt = byte_index_r + 1'b1;
      else
        byte_index_nxt = IDX_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
    if (rd_req)
      mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rd_req) begin
      fwd_data_r <= wr_data;
      rd_idx_r   <= byte_index_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      fwd_r        <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      // take the byte being written this edge when it hits the same entry
      if (rd_req)
        fwd_r <= wr_en && (wr_addr == raddr);
    end
  end

endmodule

>>> rtl/rts_ctrl.sv
// ----------------------------------------------------------------------------
// rts_ctrl
// Compare stage, repeat/hold state and registered result output.
// ----------------------------------------------------------------------------
module rts_ctrl #(
  parameter  int MAX_FRAME_BYTES = rts_pkg::DEF_MAX_FRAME_BYTES,
  localparam int AW = $clog2(MAX_FRAME_BYTES),
  localparam int IW = $clog2(MAX_FRAME_BYTES + 2)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rts_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [7:0]                          in_data,
  input  logic                                in_last,
  input  logic [7:0]                          rd_data,
  input  logic [IW-1:0]                       rd_idx,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [7:0]                          wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rts_pkg::OUT_TDATA_W-1:0]     out_data
);
  import rts_pkg::*;

  localparam logic [IW-1:0] IDX_MAX  = IW'(MAX_FRAME_BYTES);
  localparam logic [IW-1:0] IDX_OVER = IW'(MAX_FRAME_BYTES + 1);

  logic                   p1_v_r;
  logic [1:0]             p1_cmd_r;
  logic [7:0]             p1_data_r;
  logic                   p1_last_r;
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   adv;

  logic [IW-1:0] prev_len_r, prev_len_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic          repeat_r, repeat_nxt;
  logic [15:0]   age_r, age_nxt;
  logic [15:0]   hold_r, hold_nxt;
  logic          rx2_r, rx2_nxt;
  logic          retune;
  logic          in_range;
  logic          mis_now;
  logic [IW-1:0] len;
  logic          overlong;

  assign adv       = p1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !p1_v_r || !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  assign in_range = rd_idx < IDX_MAX;
  assign len      = in_range ? rd_idx + 1'b1 : IDX_OVER;
  assign overlong = len > IDX_MAX;
  assign mis_now  = mismatch_r ||
                    (have_prev_r && rd_idx < prev_len_r && rd_data != p1_data_r);

  assign wr_en   = adv && p1_cmd_r == CMD_BYTE && in_range;
  assign wr_addr = rd_idx[AW-1:0];
  assign wr_data = p1_data_r;

  always_comb begin
    prev_len_nxt  = prev_len_r;
    have_prev_nxt = have_prev_r;
    mismatch_nxt  = mismatch_r;
    repeat_nxt    = repeat_r;
    age_nxt       = age_r;
    hold_nxt      = hold_r;
    rx2_nxt       = rx2_r;
    retune        = 1'b0;
    case (p1_cmd_r)
      CMD_BYTE: begin
        if (in_range)
          mismatch_nxt = mis_now;
        if (p1_last_r) begin
          if (!overlong && have_prev_r && !(in_range ? mis_now : mismatch_r) &&
              len == prev_len_r) begin
            repeat_nxt = 1'b1;
            age_nxt    = '0;
          end else begin
            repeat_nxt = 1'b0;
          end
          have_prev_nxt = !overlong;
          prev_len_nxt  = overlong ? '0 : len;
          mismatch_nxt  = 1'b0;
        end
      end
      CMD_DOWNLINK: begin
        if (repeat_r && age_r < cfg.window) begin
          rx2_nxt  = 1'b1;
          hold_nxt = (cfg.hold == '0) ? 16'd1 : cfg.hold;
          retune   = 1'b1;
        end
      end
      CMD_TICK: begin
        if (age_r != AGE_MAX)
          age_nxt = age_r + 1'b1;
        if (rx2_r) begin
          if (hold_r <= 16'd1) begin
            hold_nxt = '0;
            rx2_nxt  = 1'b0;
            retune   = 1'b1;
          end else begin
            hold_nxt = hold_r - 1'b1;
          end
        end
      end
      default: ;
    endcase

    // pad, retune, repeat, in_rx2, invert_iq, sf, bw, freq
    if (rx2_nxt)
      out_data_nxt = {1'b0, retune, repeat_nxt, 1'b1, 1'b1,
                      cfg.rx2_sf, RX2_BW_KHZ, cfg.rx2_freq};
    else
      out_data_nxt = {1'b0, retune, repeat_nxt, 1'b0, 1'b0,
                      cfg.ul_sf, cfg.ul_bw, cfg.ul_freq};
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p1_cmd_r  <= in_cmd;
      p1_data_r <= in_data;
      p1_last_r <= in_last;
    end
    if (adv)
      out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      prev_len_r  <= '0;
      have_prev_r <= 1'b0;
      mismatch_r  <= 1'b0;
      repeat_r    <= 1'b0;
      age_r       <= '0;
      hold_r      <= '0;
      rx2_r       <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        p1_v_r <= 1'b1;
      else if (adv)
        p1_v_r <= 1'b0;
      if (adv)
        out_v_r <= 1'b1;
      else if (out_ready)
        out_v_r <= 1'b0;
      if (adv) begin
        prev_len_r  <= prev_len_nxt;
        have_prev_r <= have_prev_nxt;
        mismatch_r  <= mismatch_nxt;
        repeat_r    <= repeat_nxt;
        age_r       <= age_nxt;
        hold_r      <= hold_nxt;
        rx2_r       <= rx2_nxt;
      end
    end
  end

  a_hold_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
    rx2_r == (hold_r != '0))
    else $error("hold counter and rx2 mode disagree");

  a_repeat_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(repeat_r) |-> $past(adv && p1_cmd_r == CMD_BYTE && p1_last_r))
    else $error("repeat flag set outside a frame end");

  a_no_prev_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    !have_prev_r |-> prev_len_r == '0)
    else $error("stale previous length without a stored frame");

endmodule

>>> rtl/replay_triggered_rx2_switcher_core.sv
// ----------------------------------------------------------------------------
// replay_triggered_rx2_switcher_core
// Watches uplink frames for replays and retunes the receiver to RX2 settings
// when a downlink follows a fresh repeat.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the request (uplink byte, downlink seen,
// millisecond tick), in_tdata carries the uplink byte, in_tlast marks the
// final byte of a frame. Every request yields one result on the out_ stream
// with the current tuning (frequency, bandwidth, spreading factor, IQ
// inversion) and status (rx2 mode, repeat seen, retune).
// Each byte is compared against the same position of the previous frame in
// a frame memory with one read and one write port: read at accept, compare
// and write back as the byte leaves the compare stage, forwarding covers a
// write and a read of the same entry. Each request waits in the compare
// stage, then its result in the output register. Throughput is one request
// per cycle while out_tready is high, set by the one read and one write of
// the frame memory. Reset clears all control state; the frame memory is not
// cleared, only bytes of a stored frame are ever compared. Settings reset to
// their defaults and are written through the APB port while the block is
// idle, a rule for the user that the block does not enforce. When the result
// receiver stalls, one result waits in the output register and one request
// in the compare stage, then in_tready drops.
// ----------------------------------------------------------------------------
module replay_triggered_rx2_switcher_core #(
  parameter int MAX_FRAME_BYTES = rts_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // data_byte
  input  logic [1:0]                      in_tuser,   // command
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frequency_hz[29:0], bandwidth_khz[38:30], spreading_factor[42:39],
  // invert_iq[43], in_rx2[44], repeat_seen[45], retune[46], zero[47]
  output logic [rts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rts_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rts_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int IW = $clog2(MAX_FRAME_BYTES + 2);

  cfg_t          cfg;
  logic [7:0]    rd_data;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  rts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rts_byte_store #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (in_tvalid && in_tready),
    .rd_cmd  (in_tuser),
    .rd_last (in_tlast),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_idx  (rd_idx)
  );

  rts_ctrl #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .rd_data   (rd_data),
    .rd_idx    (rd_idx),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the replay-triggered RX2 switcher core.
// ----------------------------------------------------------------------------
// Uplink bytes, downlink events and millisecond ticks are streamed into the
// core under random gaps and output stalls. A behavioral copy of the switcher
// predicts the tuning and status for every request, and each result is
// compared field by field. Settings are written and read back over APB
// between phases while the core is idle. Directed tests cover frame repeats,
// length and byte mismatches, overlong frames, window and hold limits and
// live register writes in RX2 mode. A random part follows.
// ----------------------------------------------------------------------------
module tb_top;
  import rts_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         FRAME_MAX   = DEF_MAX_FRAME_BYTES;
  localparam int         CYCLE_LIMIT = 1000000;

  // Layout of out_tdata, highest bit first
  typedef struct packed {
    logic        pad;
    logic        retune;
    logic        repeat_seen;
    logic        in_rx2;
    logic        invert_iq;
    logic [3:0]  sf;
    logic [8:0]  bw;
    logic [29:0] freq;
  } tuning_t;

  typedef logic [7:0] byte_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'd0;   // data_byte
  logic [1:0]             in_tuser = CMD_TICK;  // command
  logic                   in_tlast = 1'b0;   // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // frequency_hz, bandwidth_khz, spreading_factor, invert_iq, in_rx2,
  // repeat_seen, retune, zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [31:0]            pwdata = 32'd0;
  logic [31:0]            prdata;
  logic                   pready;

  replay_triggered_rx2_switcher_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // Switcher state as predicted from the accepted requests
  cfg_t cfg_shadow = '{ul_freq: RST_UL_FREQ, ul_bw: RST_UL_BW, ul_sf: RST_UL_SF,
                       rx2_freq: RST_RX2_FREQ, rx2_sf: RST_RX2_SF,
                       window: RST_WINDOW, hold: RST_HOLD};
  logic [7:0]  sw_store [FRAME_MAX];
  int unsigned sw_prev_len = 0;
  int unsigned sw_index = 0;
  bit          sw_have_prev = 1'b0;
  bit          sw_mismatch = 1'b0;
  bit          sw_repeat = 1'b0;
  int unsigned sw_age = 0;
  int unsigned sw_hold = 0;
  bit          sw_rx2 = 1'b0;

  tuning_t tuning_due[$];
  byte_q_t sent_frame_q;

  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  rx2_entries = 0;
  int  repeats_found = 0;
  int  cycle_count = 0;
  int  hold_off_request = 0;
  int  stall_left = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  frame_noise = 1'b0;

  function automatic tuning_t step_switcher(logic [1:0] cmd, logic [7:0] data,
                                            logic is_last);
    tuning_t     res;
    int unsigned len;
    bit          retune;
    retune = 1'b0;
    case (cmd)
      CMD_BYTE: begin
        if (sw_index < FRAME_MAX) begin
          if (sw_have_prev && sw_index < sw_prev_len && sw_store[sw_index] != data)
            sw_mismatch = 1'b1;
          sw_store[sw_index] = data;
          sw_index++;
        end else begin
          sw_index = FRAME_MAX + 1;
        end
        if (is_last) begin
          len = sw_index;
          if (len <= FRAME_MAX && sw_have_prev && !sw_mismatch && len == sw_prev_len) begin
            sw_repeat = 1'b1;
            sw_age = 0;
            repeats_found++;
          end else begin
            sw_repeat = 1'b0;
          end
          // an overlong frame leaves nothing to compare the next one with
          sw_have_prev = (len <= FRAME_MAX);
          sw_prev_len = (len <= FRAME_MAX) ? len : 0;
          sw_index = 0;
          sw_mismatch = 1'b0;
        end
      end
      CMD_DOWNLINK: begin
        if (sw_repeat && sw_age < cfg_shadow.window) begin
          sw_rx2 = 1'b1;
          sw_hold = (cfg_shadow.hold == 16'd0) ? 1 : cfg_shadow.hold;
          retune = 1'b1;
          rx2_entries++;
        end
      end
      CMD_TICK: begin
        if (sw_age < AGE_MAX) sw_age++;
        if (sw_rx2) begin
          if (sw_hold <= 1) begin
            sw_hold = 0;
            sw_rx2 = 1'b0;
            retune = 1'b1;
          end else begin
            sw_hold--;
          end
        end
      end
      default: ;
    endcase
    res.pad = 1'b0;
    res.retune = retune;
    res.repeat_seen = sw_repeat;
    res.in_rx2 = sw_rx2;
    res.invert_iq = sw_rx2;
    res.sf = sw_rx2 ? cfg_shadow.rx2_sf : cfg_shadow.ul_sf;
    res.bw = sw_rx2 ? RX2_BW_KHZ : cfg_shadow.ul_bw;
    res.freq = sw_rx2 ? cfg_shadow.rx2_freq : cfg_shadow.ul_freq;
    return res;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_UL_FREQ:  return {2'b00, cfg_shadow.ul_freq};
      REG_UL_BW:    return {23'd0, cfg_shadow.ul_bw};
      REG_UL_SF:    return {28'd0, cfg_shadow.ul_sf};
      REG_RX2_FREQ: return {2'b00, cfg_shadow.rx2_freq};
      REG_RX2_SF:   return {28'd0, cfg_shadow.rx2_sf};
      REG_WINDOW:   return {16'd0, cfg_shadow.window};
      REG_HOLD:     return {16'd0, cfg_shadow.hold};
      default:      return 32'd0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    tuning_t got;
    tuning_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = tuning_t'(out_tdata);
      results_seen++;
      if (tuning_due.size() == 0) begin
        note_mismatch("unrequested result", 32'd0, out_tdata[31:0]);
      end else begin
        want = tuning_due.pop_front();
        if (got.freq !== want.freq)
          note_mismatch("frequency_hz", 32'(want.freq), 32'(got.freq));
        if (got.bw !== want.bw) note_mismatch("bandwidth_khz", 32'(want.bw), 32'(got.bw));
        if (got.sf !== want.sf)
          note_mismatch("spreading_factor", 32'(want.sf), 32'(got.sf));
        if (got.invert_iq !== want.invert_iq)
          note_mismatch("invert_iq", 32'(want.invert_iq), 32'(got.invert_iq));
        if (got.in_rx2 !== want.in_rx2)
          note_mismatch("in_rx2", 32'(want.in_rx2), 32'(got.in_rx2));
        if (got.repeat_seen !== want.repeat_seen)
          note_mismatch("repeat_seen", 32'(want.repeat_seen), 32'(got.repeat_seen));
        if (got.retune !== want.retune)
          note_mismatch("retune", 32'(want.retune), 32'(got.retune));
        if (got.pad !== 1'b0) note_mismatch("pad bit", 32'd0, 32'(got.pad));
      end
    end
  end

  // Result receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (hold_off_request > 0) begin
      out_tready <= 1'b0;
      stall_left = hold_off_request - 1;
      hold_off_request = 0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
    // keep in_tvalid up; a gap before the next request or the drain lowers it
    tuning_due.push_back(step_switcher(cmd, data, is_last));
    requests_sent++;
  endtask

  task automatic send_frame(input byte_q_t bytes);
    foreach (bytes[i]) begin
      if (frame_noise && $urandom_range(0, 29) == 0)
        send_item($urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(CMD_BYTE, bytes[i], i == bytes.size() - 1);
    end
    sent_frame_q = bytes;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_downlink();
    send_item(CMD_DOWNLINK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tuning_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_check(input logic [2:0] idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== reg_value(idx)) note_mismatch($sformatf("register %0d", idx), reg_value(idx), got);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_UL_FREQ:  cfg_shadow.ul_freq = value[29:0];
      REG_UL_BW:    cfg_shadow.ul_bw = value[8:0];
      REG_UL_SF:    cfg_shadow.ul_sf = value[3:0];
      REG_RX2_FREQ: cfg_shadow.rx2_freq = value[29:0];
      REG_RX2_SF:   cfg_shadow.rx2_sf = value[3:0];
      REG_WINDOW:   cfg_shadow.window = value[15:0];
      REG_HOLD:     cfg_shadow.hold = value[15:0];
      default: ;
    endcase
    cfg_check(idx);
  endtask

  task automatic test_defaults();
    cfg_check(REG_UL_FREQ);
    cfg_check(REG_UL_BW);
    cfg_check(REG_UL_SF);
    cfg_check(REG_RX2_FREQ);
    cfg_check(REG_RX2_SF);
    cfg_check(REG_WINDOW);
    cfg_check(REG_HOLD);
    send_ticks(1);
    send_downlink();
    send_item(CMD_UNUSED, 8'hFF, 1'b1);
    send_item(CMD_UNUSED, 8'h00, 1'b0);
  endtask

  task automatic test_replay_switch();
    cfg_write(REG_WINDOW, 32'd4);
    cfg_write(REG_HOLD, 32'd3);
    send_frame('{8'h00, 8'hFF, 8'hA5});
    send_frame('{8'h00, 8'hFF, 8'hA5});
    send_downlink();
    send_ticks(1);
    send_downlink();   // re-arm the hold while already in rx2
    send_ticks(3);
    send_frame('{8'h00, 8'hFF, 8'hA4});
    send_frame('{8'h00, 8'hFF});  // equal prefix, shorter frame
    send_frame('{8'h80});
    send_frame('{8'h80});
    send_ticks(4);
    send_downlink();   // repeat now as old as the window
  endtask

  task automatic test_zero_window_hold();
    cfg_write(REG_WINDOW, 32'd0);
    cfg_write(REG_HOLD, 32'd0);
    send_frame('{8'h33});
    send_frame('{8'h33});
    send_downlink();
    cfg_write(REG_WINDOW, 32'd1);
    send_downlink();
    send_ticks(2);
  endtask

  task automatic test_live_rx2_write();
    cfg_write(REG_WINDOW, 32'hFFFF);
    cfg_write(REG_HOLD, 32'hFFFF);
    send_frame('{8'hC3, 8'h3C});
    send_frame('{8'hC3, 8'h3C});
    send_downlink();
    cfg_write(REG_RX2_FREQ, $urandom_range(137000000, 1020000000));
    cfg_write(REG_RX2_SF, 32'd6);
    cfg_write(REG_UL_FREQ, $urandom_range(137000000, 1020000000));
    cfg_write(REG_UL_BW, 32'd500);
    cfg_write(REG_UL_SF, 32'd7);
    send_ticks(1);
    cfg_write(REG_HOLD, 32'd1);
    send_downlink();
    send_ticks(2);
  endtask

  task automatic test_config_extremes();
    // upper bits beyond each field must be dropped
    cfg_write(REG_UL_FREQ, 32'hFFFF_FFFF);
    cfg_write(REG_UL_BW, 32'h0000_0000);
    cfg_write(REG_UL_SF, 32'hFFFF_FFF0);
    cfg_write(REG_RX2_FREQ, 32'h0000_0000);
    cfg_write(REG_RX2_SF, 32'hFFFF_FFFF);
    cfg_write(REG_WINDOW, 32'hFFFF_FFFF);
    cfg_write(REG_HOLD, 32'hFFFF_0000);
    send_ticks(1);
    send_frame('{8'hFF});
    send_frame('{8'hFF});
    send_downlink();
    send_ticks(2);
    cfg_write(REG_UL_FREQ, 32'd0);
    cfg_write(REG_UL_BW, 32'h1FF);
    cfg_write(REG_UL_SF, 32'hF);
    cfg_write(REG_RX2_FREQ, 32'h3FFF_FFFF);
    cfg_write(REG_RX2_SF, 32'd0);
    cfg_write(REG_WINDOW, 32'd1);
    cfg_write(REG_HOLD, 32'd1);
    send_downlink();
    send_frame('{8'hFF});
    send_downlink();
    send_ticks(1);
  endtask

  task automatic test_overlong_frames();
    send_frame('{8'h01, 8'h02});
    send_frame(random_bytes(FRAME_MAX + 1));
    send_frame('{8'h01, 8'h02});   // nothing to compare with after an overlong frame
    send_frame('{8'h01, 8'h02});
  endtask

  task automatic test_backpressure();
    cfg_write(REG_WINDOW, 32'd50);
    cfg_write(REG_HOLD, 32'd5);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_off_request = 60;
    send_frame(random_bytes(12));
    send_frame(sent_frame_q);
    send_downlink();
    send_ticks(10);
    wait_drained();
    send_downlink();
    send_ticks(6);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic random_traffic(input int n);
    int      counted;
    int      r;
    int      k;
    int      pos;
    byte_q_t frame;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = $urandom_range(0, 99);
        frame = sent_frame_q;
        if (sent_frame_q.size() == 0 || k >= 80) begin
          frame = random_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                            : $urandom_range(1, 6));
        end else if (k >= 65) begin
          pos = $urandom_range(0, frame.size() - 1);
          frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
        end else if (k >= 55) begin
          if (frame.size() > 1 && $urandom_range(0, 1)) void'(frame.pop_back());
          else frame.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(frame);
        counted += frame.size();
      end else if (r < 70) begin
        send_downlink();
        counted++;
      end else if (r < 95) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_ticks(k);
        counted += k;
      end else begin
        send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random();
    int window_sel [4];
    int hold_sel [4];
    window_sel = '{$urandom_range(1, 12), 65535, 1, $urandom_range(2, 30)};
    hold_sel = '{$urandom_range(1, 6), 1, 65535, 0};
    frame_noise = 1'b1;
    for (int p = 0; p < 4; p++) begin
      cfg_write(REG_UL_FREQ, $urandom_range(137000000, 1020000000));
      cfg_write(REG_UL_BW, $urandom_range(7, 500));
      cfg_write(REG_UL_SF, $urandom_range(6, 12));
      cfg_write(REG_RX2_FREQ, $urandom_range(137000000, 1020000000));
      cfg_write(REG_RX2_SF, $urandom_range(6, 12));
      cfg_write(REG_WINDOW, window_sel[p]);
      cfg_write(REG_HOLD, hold_sel[p]);
      tx_idle_on = (p != 1);
      rx_idle_on = (p != 2);
      random_traffic(25);
    end
    frame_noise = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_replay_switch();
    test_zero_window_hold();
    test_live_rx2_write();
    test_config_extremes();
    test_overlong_frames();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("requests %0d, results %0d, repeats detected %0d, rx2 switches %0d",
             requests_sent, results_seen, repeats_found, rx2_entries);
    $display("directed repeat/window/hold/overlong cases, live writes, random phases");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
